// ===== rtl/core/bicubic_lagrange_interpolator_top_macros.svh =====
// assertion macros used by the interpolator controller
`ifndef BICUBIC_LAGRANGE_INTERPOLATOR_TOP_MACROS_SVH
`define BICUBIC_LAGRANGE_INTERPOLATOR_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define BLI_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define BLI_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/bli_pkg.sv =====
// shared constants, types and control structs of the bicubic interpolator
`default_nettype none

package bli_pkg;

	// field sizes
	localparam int SAMPLE_BITS  = 16;
	localparam int FRAC_BITS    = 12;
	localparam int WEIGHT_BITS  = 14;
	localparam int TAPS         = 4;
	localparam int ROW_IDX_BITS = 2;
	localparam int PIX_BITS     = 17;

	// datapath widths
	localparam int W_BITS    = WEIGHT_BITS + 2;
	localparam int ROW_BITS  = SAMPLE_BITS + W_BITS;
	localparam int TERM_BITS = ROW_BITS + W_BITS;
	localparam int ACC_BITS  = TERM_BITS + 2;
	localparam int PIX_SHIFT = 2 * WEIGHT_BITS;
	localparam int RND_BITS  = ACC_BITS - PIX_SHIFT;

	// basis polynomial widths
	localparam int OP_BITS    = FRAC_BITS + 2;
	localparam int PROD1_BITS = 2 * OP_BITS;
	localparam int PROD2_BITS = PROD1_BITS + OP_BITS;
	localparam int NUM_BITS   = PROD2_BITS + 2;
	localparam int RND_SHIFT  = 3 * FRAC_BITS - WEIGHT_BITS;
	localparam int Q_BITS     = NUM_BITS - RND_SHIFT;

	// divide by six through a reciprocal multiply
	localparam int X_BITS        = WEIGHT_BITS + 5;
	localparam int RCP_SHIFT     = X_BITS + 6;
	localparam int RCP_MUL       = (1 << RCP_SHIFT) / 6 + 1;
	localparam int RCP_MUL_BITS  = RCP_SHIFT - 2;
	localparam int RCP_PROD_BITS = X_BITS + RCP_MUL_BITS;
	localparam int WGT_OFFS      = 1 << (WEIGHT_BITS - 2);
	localparam int RCP_OFFS      = 6 * WGT_OFFS;

	// cycles from a new fraction to settled weights
	localparam int BASIS_LAT = 5;
	localparam int CNT_BITS  = $clog2(BASIS_LAT);

	typedef logic signed [SAMPLE_BITS-1:0] smp_t;
	typedef logic signed [W_BITS-1:0]      wgt_t;
	typedef logic        [FRAC_BITS-1:0]   frac_t;
	typedef logic        [ROW_IDX_BITS-1:0] row_idx_t;
	typedef logic signed [ROW_BITS-1:0]    row_t;
	typedef logic signed [PIX_BITS-1:0]    pix_t;

	localparam row_idx_t ROW_FIRST = row_idx_t'(0);
	localparam row_idx_t ROW_LAST  = row_idx_t'(TAPS - 1);

	// controller to datapath commands
	typedef struct packed {
		logic capture;
		logic mul_en;
		logic row_wr;
		logic ymul_en;
		logic ysum_en;
		logic out_load;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic row_zero_in;
		logic row_last;
	} stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/bli_row_if.sv =====
// channel carrying one window row request
`default_nettype none

interface bli_row_if import bli_pkg::*; ();
	logic     valid;
	logic     ready;
	smp_t     sample_0;
	smp_t     sample_1;
	smp_t     sample_2;
	smp_t     sample_3;
	row_idx_t row_index;
	frac_t    frac_x;
	frac_t    frac_y;

	modport source (
		output valid, sample_0, sample_1, sample_2, sample_3, row_index, frac_x, frac_y,
		input  ready
	);
	modport sink (
		input  valid, sample_0, sample_1, sample_2, sample_3, row_index, frac_x, frac_y,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/core/bli_pix_if.sv =====
// channel carrying one interpolated pixel request
`default_nettype none

interface bli_pix_if import bli_pkg::*; ();
	logic valid;
	logic ready;
	pix_t pixel_value;

	modport source (output valid, pixel_value, input ready);
	modport sink (input valid, pixel_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bli_basis.sv =====
// five-stage pipeline turning a fraction into four cubic lagrange weights
`default_nettype none

module bli_basis import bli_pkg::*; (
	input  wire logic clk,
	input  wire frac_t frac,
	output wgt_t      wgt [TAPS]
);

	localparam logic signed [OP_BITS-1:0]  FRAC_ONE   = OP_BITS'(1) << FRAC_BITS;
	localparam logic signed [OP_BITS-1:0]  FRAC_TWO   = OP_BITS'(2) << FRAC_BITS;
	localparam logic signed [NUM_BITS-1:0] RND_HALF   = NUM_BITS'(3) << RND_SHIFT;
	localparam logic signed [Q_BITS-1:0]   RCP_OFFS_Q = Q_BITS'(RCP_OFFS);
	localparam logic [RCP_MUL_BITS-1:0]    RCP_MUL_C  = RCP_MUL_BITS'(RCP_MUL);
	localparam logic signed [W_BITS-1:0]   WGT_OFFS_W = W_BITS'(WGT_OFFS);

	logic signed [OP_BITS-1:0]    op_u, op_a, op_c, op_e;
	logic signed [OP_BITS-1:0]    a_s1, b_s1, c_s1, e_s1;
	logic signed [PROD1_BITS-1:0] p_s1, q_s1;
	logic signed [PROD2_BITS-1:0] m_s2 [TAPS];
	logic signed [NUM_BITS-1:0]   num [TAPS];
	logic signed [Q_BITS-1:0]     q_s3 [TAPS];
	logic        [X_BITS-1:0]     x_d [TAPS];
	logic [RCP_PROD_BITS-1:0]     prod_s4 [TAPS];
	wgt_t                         w_s5 [TAPS];

	// node offsets: t+1, t, t-1, t-2 in units of one sample step
	assign op_u = signed'({2'b00, frac});
	assign op_a = op_u + FRAC_ONE;
	assign op_c = op_u - FRAC_ONE;
	assign op_e = op_u - FRAC_TWO;

	// stage 1: shared pair products
	always_ff @(posedge clk) begin
		a_s1 <= op_a;
		b_s1 <= op_u;
		c_s1 <= op_c;
		e_s1 <= op_e;
		p_s1 <= PROD1_BITS'(op_c) * PROD1_BITS'(op_e);
		q_s1 <= PROD1_BITS'(op_a) * PROD1_BITS'(op_u);
	end

	// stage 2: cubic products
	always_ff @(posedge clk) begin
		m_s2[0] <= PROD2_BITS'(b_s1) * PROD2_BITS'(p_s1);
		m_s2[1] <= PROD2_BITS'(a_s1) * PROD2_BITS'(p_s1);
		m_s2[2] <= PROD2_BITS'(q_s1) * PROD2_BITS'(e_s1);
		m_s2[3] <= PROD2_BITS'(q_s1) * PROD2_BITS'(c_s1);
	end

	// numerator signs and factors of three
	always_comb begin
		num[0] = -NUM_BITS'(m_s2[0]);
		num[1] = (NUM_BITS'(m_s2[1]) <<< 1) + NUM_BITS'(m_s2[1]);
		num[2] = -((NUM_BITS'(m_s2[2]) <<< 1) + NUM_BITS'(m_s2[2]));
		num[3] = NUM_BITS'(m_s2[3]);
	end

	// stage 3: add half a divisor and drop the power-of-two part
	always_ff @(posedge clk) begin
		for (int k = 0; k < TAPS; k++) begin
			q_s3[k] <= Q_BITS'((num[k] + RND_HALF) >>> RND_SHIFT);
		end
	end

	// stage 4: bias positive and multiply by the reciprocal of six
	always_comb begin
		for (int k = 0; k < TAPS; k++) begin
			x_d[k] = X_BITS'(q_s3[k] + RCP_OFFS_Q);
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < TAPS; k++) begin
			prod_s4[k] <= RCP_PROD_BITS'(x_d[k]) * RCP_PROD_BITS'(RCP_MUL_C);
		end
	end

	// stage 5: quotient less the bias
	always_ff @(posedge clk) begin
		for (int k = 0; k < TAPS; k++) begin
			w_s5[k] <= W_BITS'(prod_s4[k] >> RCP_SHIFT) - WGT_OFFS_W;
		end
	end

	assign wgt = w_s5;

endmodule

`default_nettype wire

// ===== rtl/core/bli_ctrl.sv =====
// sequencer for reset warm-up, row intake, weight settling, y pass and pixel output
`default_nettype none

`include "bicubic_lagrange_interpolator_top_macros.svh"

module bli_ctrl import bli_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  rows_valid,
	output logic       rows_ready,
	output logic       pix_valid,
	input  wire logic  pix_ready,
	input  wire stat_t stat,
	output cmd_t       cmd
);

	typedef enum logic [7:0] {
		ST_WARM = 8'b0000_0001,
		ST_IDLE = 8'b0000_0010,
		ST_WGT  = 8'b0000_0100,
		ST_MUL  = 8'b0000_1000,
		ST_ROW  = 8'b0001_0000,
		ST_YMUL = 8'b0010_0000,
		ST_YSUM = 8'b0100_0000,
		ST_SAT  = 8'b1000_0000
	} state_t;

	localparam logic [CNT_BITS-1:0] CNT_LOAD = CNT_BITS'(BASIS_LAT - 1);

	state_t              state_q, state_d;
	logic [CNT_BITS-1:0] cnt_q, cnt_d;
	logic                out_valid_q;

	// next state and commands
	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		cmd        = '0;
		rows_ready = 1'b0;
		case (state_q)
			ST_WARM: begin
				if (cnt_q == '0) begin
					state_d = ST_IDLE;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			ST_IDLE: begin
				rows_ready = 1'b1;
				if (rows_valid) begin
					cmd.capture = 1'b1;
					if (stat.row_zero_in) begin
						state_d = ST_WGT;
						cnt_d   = CNT_LOAD;
					end else begin
						state_d = ST_MUL;
					end
				end
			end
			ST_WGT: begin
				if (cnt_q == '0) begin
					state_d = ST_MUL;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			ST_MUL: begin
				cmd.mul_en = 1'b1;
				state_d    = ST_ROW;
			end
			ST_ROW: begin
				cmd.row_wr = 1'b1;
				state_d    = stat.row_last ? ST_YMUL : ST_IDLE;
			end
			ST_YMUL: begin
				cmd.ymul_en = 1'b1;
				state_d     = ST_YSUM;
			end
			ST_YSUM: begin
				cmd.ysum_en = 1'b1;
				state_d     = ST_SAT;
			end
			ST_SAT: begin
				if (!out_valid_q || pix_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state and settle counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_WARM;
			cnt_q   <= CNT_LOAD;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// output request flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (pix_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign pix_valid = out_valid_q;

	`BLI_ASSERT_NOW(a_load_free, cmd.out_load, !out_valid_q || pix_ready, "pixel overwritten")
	`BLI_ASSERT_NEXT(a_busy_after_req, rows_valid && rows_ready, !rows_ready, "row taken twice")
	`BLI_ASSERT_NEXT(a_last_row_ypass, cmd.row_wr && stat.row_last, cmd.ymul_en, "no y pass")
	`BLI_ASSERT_NEXT(a_wgt_to_mul, (state_q == ST_WGT) && (cnt_q == '0), cmd.mul_en, "no row mul")

endmodule

`default_nettype wire

// ===== rtl/core/bli_dp.sv =====
// datapath: fraction latches, row weighting, row store, y weighting and rounding
`default_nettype none

module bli_dp import bli_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire cmd_t     cmd,
	input  wire smp_t     sample_0,
	input  wire smp_t     sample_1,
	input  wire smp_t     sample_2,
	input  wire smp_t     sample_3,
	input  wire row_idx_t row_index,
	input  wire frac_t    frac_x,
	input  wire frac_t    frac_y,
	output stat_t         stat,
	output pix_t          pixel_value
);

	localparam logic signed [ACC_BITS-1:0] PIX_HALF = ACC_BITS'(1) << (PIX_SHIFT - 1);
	localparam logic signed [RND_BITS-1:0] SAT_LO   = RND_BITS'(-(1 << (PIX_BITS - 1)));
	localparam logic signed [RND_BITS-1:0] SAT_HI   = RND_BITS'((1 << (PIX_BITS - 1)) - 1);
	localparam pix_t PIX_MIN = PIX_BITS'(-(1 << (PIX_BITS - 1)));
	localparam pix_t PIX_MAX = PIX_BITS'((1 << (PIX_BITS - 1)) - 1);

	frac_t                         held_frac_x_q, held_frac_y_q;
	smp_t                          smp_q [TAPS];
	row_idx_t                      row_q;
	wgt_t                          wx [TAPS];
	wgt_t                          wy [TAPS];
	row_t                          xprod_s1 [TAPS];
	row_t                          row_sum;
	row_t                          row_partials_q [TAPS];
	logic signed [TERM_BITS-1:0]   yprod_s1 [TAPS];
	logic signed [ACC_BITS-1:0]    acc_q;
	logic signed [ACC_BITS-1:0]    acc_d;
	logic signed [RND_BITS-1:0]    rnd;
	pix_t                          pix_sat;
	pix_t                          pixel_q;

	// fractions held from the most recent first row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_frac_x_q <= '0;
			held_frac_y_q <= '0;
		end else if (cmd.capture && (row_index == ROW_FIRST)) begin
			held_frac_x_q <= frac_x;
			held_frac_y_q <= frac_y;
		end
	end

	// row request capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			smp_q[0] <= sample_0;
			smp_q[1] <= sample_1;
			smp_q[2] <= sample_2;
			smp_q[3] <= sample_3;
			row_q    <= row_index;
		end
	end

	assign stat.row_zero_in = (row_index == ROW_FIRST);
	assign stat.row_last    = (row_q == ROW_LAST);

	// weight pipelines for both axes
	bli_basis u_basis_x (
		.clk  (clk),
		.frac (held_frac_x_q),
		.wgt  (wx)
	);

	bli_basis u_basis_y (
		.clk  (clk),
		.frac (held_frac_y_q),
		.wgt  (wy)
	);

	// x weighting of the row
	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			for (int k = 0; k < TAPS; k++) begin
				xprod_s1[k] <= ROW_BITS'(smp_q[k]) * ROW_BITS'(wx[k]);
			end
		end
	end

	always_comb begin
		row_sum = '0;
		for (int k = 0; k < TAPS; k++) begin
			row_sum = row_sum + xprod_s1[k];
		end
	end

	// row value store
	always_ff @(posedge clk) begin
		if (cmd.row_wr) begin
			row_partials_q[row_q] <= row_sum;
		end
	end

	// y weighting of the stored rows
	always_ff @(posedge clk) begin
		if (cmd.ymul_en) begin
			for (int r = 0; r < TAPS; r++) begin
				yprod_s1[r] <= TERM_BITS'(row_partials_q[r]) * TERM_BITS'(wy[r]);
			end
		end
	end

	// column sum with the rounding half added
	always_comb begin
		acc_d = PIX_HALF;
		for (int r = 0; r < TAPS; r++) begin
			acc_d = acc_d + ACC_BITS'(yprod_s1[r]);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ysum_en) begin
			acc_q <= acc_d;
		end
	end

	// drop fraction bits and clamp to the pixel range
	assign rnd = acc_q[ACC_BITS-1:PIX_SHIFT];

	always_comb begin
		if (rnd < SAT_LO) begin
			pix_sat = PIX_MIN;
		end else if (rnd > SAT_HI) begin
			pix_sat = PIX_MAX;
		end else begin
			pix_sat = rnd[PIX_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			pixel_q <= pix_sat;
		end
	end

	assign pixel_value = pixel_q;

endmodule

`default_nettype wire

// ===== rtl/core/bicubic_lagrange_interpolator_top.sv =====
// Row 0 request: intake, x/y weight pipeline settling in the weight wait state, multiply, store.
// Rows 1 and 2: intake, multiply, store each; the single row multiplier set paces them.
// Row 3: intake, multiply, store, y multiply, y sum, then the pixel output load, which waits
// as long as the output register is full and not being emptied; the next row is taken after it.
// Reset: controller waits for the weight pipelines, held fractions clear to zero,
// the row store is left unset until written.
`default_nettype none

module bicubic_lagrange_interpolator_top import bli_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	bli_row_if.sink   rows,
	bli_pix_if.source pixels
);

	cmd_t  cmd;
	stat_t stat;

	// sequencer
	bli_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.rows_valid (rows.valid),
		.rows_ready (rows.ready),
		.pix_valid  (pixels.valid),
		.pix_ready  (pixels.ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	// arithmetic
	bli_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sample_0    (rows.sample_0),
		.sample_1    (rows.sample_1),
		.sample_2    (rows.sample_2),
		.sample_3    (rows.sample_3),
		.row_index   (rows.row_index),
		.frac_x      (rows.frac_x),
		.frac_y      (rows.frac_y),
		.stat        (stat),
		.pixel_value (pixels.pixel_value)
	);

endmodule

`default_nettype wire
